// ===== sv/scke_pkg.sv =====
package scke_pkg;

	localparam int NUM_BINS = 26;
	localparam int BIN_W = 5;
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

	localparam int MAX_LEN_DEFAULT = 65535;

	// scale of the observed count so that it lines up with tenths of a percent
	localparam int OBS_SCALE = 1000;

	localparam int CHAR_W = 8;
	localparam logic [CHAR_W-1:0] UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] UPPER_Z = 8'd90;
	localparam logic [CHAR_W-1:0] LOWER_A = 8'd97;
	localparam logic [CHAR_W-1:0] LOWER_Z = 8'd122;

	localparam int E_W = 8;
	localparam int SCORE_W = 57;
	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
	localparam int TOTAL_W = 16;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// quotient bits resolved per divider cycle
	localparam int DIV_RADIX_BITS = 4;

	// expected letter frequency A..Z in tenths of a percent
	localparam logic [E_W-1:0] EXPECTED_TENTHS [NUM_BINS] = '{
		8'd139, 8'd10, 8'd44, 8'd54, 8'd122, 8'd10, 8'd12, 8'd8, 8'd69, 8'd4,
		8'd1, 8'd28, 8'd42, 8'd53, 8'd108, 8'd29, 8'd9, 8'd69, 8'd79, 8'd49,
		8'd40, 8'd13, 8'd0, 8'd3, 8'd0, 8'd4
	};

	function automatic logic [E_W-1:0] expected_tenths(input logic [BIN_W-1:0] l);
		return EXPECTED_TENTHS[l];
	endfunction

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [BIN_W-1:0]   best_key;
		logic [SCORE_W-1:0] best_score;
		logic [TOTAL_W-1:0] letter_total;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic             count_en;
		logic             score_start;
		logic             load;
		logic             diff;
		logic             sqr;
		logic             div_start;
		logic             acc;
		logic             shift_end;
		logic             finish;
		logic [BIN_W-1:0] l;
		logic [BIN_W-1:0] k;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

// ===== sv/scke_div.sv =====
module scke_div #(
	parameter int DVD_W = 52,
	parameter int DVS_W = scke_pkg::E_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int R = scke_pkg::DIV_RADIX_BITS;
	localparam int STEPS = (DVD_W + R - 1) / R;
	localparam int PAD_W = STEPS * R;
	localparam int STEP_CNT_W = $clog2(STEPS + 1);

	logic [PAD_W-1:0]      shreg_q;
	logic [DVS_W-1:0]      rem_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  done_q;
	logic [PAD_W-1:0]      shreg_nx;
	logic [DVS_W-1:0]      rem_nx;

	// restoring division, R quotient bits per cycle; the register holds the
	// remaining dividend bits on top and collects quotient bits at the bottom
	always_comb begin
		logic [DVS_W:0]   trial;
		logic [DVS_W-1:0] r;
		logic [PAD_W-1:0] s;
		logic             qb;
		r = rem_q;
		s = shreg_q;
		for (int j = 0; j < R; j++) begin
			trial = {r, s[PAD_W-1]};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
				qb = 1'b1;
			end else begin
				qb = 1'b0;
			end
			r = trial[DVS_W-1:0];
			s = {s[PAD_W-2:0], qb};
		end
		rem_nx = r;
		shreg_nx = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= STEP_CNT_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= PAD_W'(dividend);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			shreg_q <= shreg_nx;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quotient = shreg_q[DVD_W-1:0];

`ifndef SYNTH
	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> cnt_q == '0)
		else $error("divider started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> cnt_q == '0)
		else $error("divider done while steps remain");
`endif

endmodule

// ===== sv/scke_dp.sv =====
module scke_dp #(
	parameter int MAX_LEN = scke_pkg::MAX_LEN_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  scke_pkg::item_t     item,
	input  scke_pkg::cmd_t      cmd,
	output scke_pkg::sts_t      sts,
	output logic                result_valid,
	input  logic                result_ready,
	output scke_pkg::result_t   result
);

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int DIFF_W = $clog2(scke_pkg::OBS_SCALE * MAX_LEN + 1);
	localparam int SQ_W = 2 * DIFF_W;
	localparam int ACC_W = ((SQ_W > scke_pkg::SCORE_W) ? SQ_W : scke_pkg::SCORE_W) + 1;
	localparam int XT_W = (CNT_W > scke_pkg::TOTAL_W) ? CNT_W : scke_pkg::TOTAL_W;

	logic [CNT_W-1:0]            counts_q [scke_pkg::NUM_BINS];
	logic [CNT_W-1:0]            total_q;
	logic                        sat_q;
	logic [DIFF_W-1:0]           obs_q;
	logic [DIFF_W-1:0]           expv_q;
	logic [DIFF_W-1:0]           diff_q;
	logic [SQ_W-1:0]             sq_q;
	logic [scke_pkg::E_W-1:0]    e_q;
	logic [scke_pkg::SCORE_W-1:0] sum_q;
	logic [scke_pkg::SCORE_W-1:0] best_q;
	logic [scke_pkg::BIN_W-1:0]  best_key_q;
	logic                        out_valid_q;
	scke_pkg::result_t           result_q;

	logic                        is_upper;
	logic                        is_lower;
	logic [scke_pkg::CHAR_W-1:0] char_off;
	logic [scke_pkg::BIN_W-1:0]  bin;
	logic                        at_max;
	logic                        count_hit;
	logic [scke_pkg::BIN_W:0]    rot;
	logic [scke_pkg::BIN_W-1:0]  rd_idx;
	logic [CNT_W-1:0]            rd_cnt;
	logic [scke_pkg::E_W-1:0]    e_cur;
	logic [ACC_W-1:0]            acc_sum;
	logic [XT_W-1:0]             total_ext;
	logic [scke_pkg::TOTAL_W-1:0] total_clamped;
	logic                        div_done;
	logic [SQ_W-1:0]             quot;

	// case-fold the byte into a bin
	assign is_upper = (item.char_code >= scke_pkg::UPPER_A) && (item.char_code <= scke_pkg::UPPER_Z);
	assign is_lower = (item.char_code >= scke_pkg::LOWER_A) && (item.char_code <= scke_pkg::LOWER_Z);
	assign char_off = is_upper ? (item.char_code - scke_pkg::UPPER_A)
	                           : (item.char_code - scke_pkg::LOWER_A);
	assign bin = char_off[scke_pkg::BIN_W-1:0];
	assign at_max = (total_q == CNT_W'(MAX_LEN));
	assign count_hit = cmd.count_en && (is_upper || is_lower) && !at_max;

	// bin (l + k) mod 26
	assign rot = {1'b0, cmd.l} + {1'b0, cmd.k};
	assign rd_idx = (rot >= (scke_pkg::BIN_W + 1)'(scke_pkg::NUM_BINS))
		? scke_pkg::BIN_W'(rot - (scke_pkg::BIN_W + 1)'(scke_pkg::NUM_BINS))
		: rot[scke_pkg::BIN_W-1:0];
	assign rd_cnt = counts_q[rd_idx];
	assign e_cur = scke_pkg::expected_tenths(cmd.l);

	assign acc_sum = ACC_W'(sum_q) + ACC_W'(quot);

	assign total_ext = XT_W'(total_q);
	assign total_clamped = (total_ext > XT_W'(scke_pkg::TOTAL_MAX))
		? scke_pkg::TOTAL_MAX : total_ext[scke_pkg::TOTAL_W-1:0];

	scke_div #(
		.DVD_W (SQ_W),
		.DVS_W (scke_pkg::E_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sq_q),
		.divisor  (e_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < scke_pkg::NUM_BINS; i++) begin
				counts_q[i] <= '0;
			end
			total_q <= '0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				for (int i = 0; i < scke_pkg::NUM_BINS; i++) begin
					counts_q[i] <= '0;
				end
				total_q <= '0;
				sat_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (cmd.count_en && (is_upper || is_lower)) begin
				if (at_max) begin
					// drop the letter
					sat_q <= 1'b1;
				end else begin
					total_q <= total_q + 1'b1;
				end
				for (int i = 0; i < scke_pkg::NUM_BINS; i++) begin
					if (count_hit && bin == scke_pkg::BIN_W'(i)) begin
						counts_q[i] <= counts_q[i] + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			obs_q <= DIFF_W'(rd_cnt) * DIFF_W'(scke_pkg::OBS_SCALE);
			expv_q <= DIFF_W'(e_cur) * DIFF_W'(total_q);
			e_q <= e_cur;
		end
		if (cmd.diff) begin
			diff_q <= (obs_q >= expv_q) ? (obs_q - expv_q) : (expv_q - obs_q);
		end
		if (cmd.sqr) begin
			sq_q <= SQ_W'(diff_q) * SQ_W'(diff_q);
		end
		if (cmd.score_start || cmd.shift_end) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= (acc_sum > ACC_W'(scke_pkg::SCORE_MAX))
				? scke_pkg::SCORE_MAX : acc_sum[scke_pkg::SCORE_W-1:0];
		end
		// keep the lowest shift on ties
		if (cmd.shift_end && (cmd.k == '0 || sum_q < best_q)) begin
			best_q <= sum_q;
			best_key_q <= cmd.k;
		end
		if (cmd.finish) begin
			result_q.best_key <= best_key_q;
			result_q.best_score <= best_q;
			result_q.letter_total <= total_clamped;
			result_q.overflow <= sat_q;
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid_q && !result_ready;
	assign result_valid = out_valid_q;
	assign result = result_q;

`ifndef SYNTH
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_LEN))
		else $error("letter total above saturation limit");
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (total_q == '0) && !sat_q && result_valid)
		else $error("histogram not cleared or result not posted after scoring");
	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && !result_ready))
		else $error("result overwritten before it was taken");
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.best_key <= scke_pkg::LAST_BIN)
		else $error("best key out of range");
`endif

endmodule

// ===== sv/scke_ctrl.sv =====
module scke_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           item_last,
	output logic           item_ready,
	input  scke_pkg::sts_t sts,
	output scke_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_DIFF,
		S_SQR,
		S_DIV_GO,
		S_DIV_WAIT,
		S_ACC,
		S_SHIFT_END,
		S_FINISH
	} state_t;

	state_t                     state_q;
	logic [scke_pkg::BIN_W-1:0] l_q;
	logic [scke_pkg::BIN_W-1:0] k_q;
	logic                       weight_zero;

	assign weight_zero = (scke_pkg::expected_tenths(l_q) == '0);
	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.l = l_q;
		cmd.k = k_q;
		cmd.count_en = (state_q == S_IDLE) && item_valid;
		cmd.score_start = (state_q == S_IDLE) && item_valid && item_last;
		cmd.load = (state_q == S_LOAD) && !weight_zero;
		cmd.diff = (state_q == S_DIFF);
		cmd.sqr = (state_q == S_SQR);
		cmd.div_start = (state_q == S_DIV_GO);
		cmd.acc = (state_q == S_ACC);
		cmd.shift_end = (state_q == S_SHIFT_END);
		cmd.finish = (state_q == S_FINISH) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			l_q <= '0;
			k_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid && item_last) begin
						l_q <= '0;
						k_q <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					// skip letters with no expected weight
					if (!weight_zero) begin
						state_q <= S_DIFF;
					end else if (l_q == scke_pkg::LAST_BIN) begin
						state_q <= S_SHIFT_END;
					end else begin
						l_q <= l_q + 1'b1;
					end
				end
				S_DIFF: state_q <= S_SQR;
				S_SQR: state_q <= S_DIV_GO;
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (sts.div_done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (l_q == scke_pkg::LAST_BIN) begin
						state_q <= S_SHIFT_END;
					end else begin
						l_q <= l_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_SHIFT_END: begin
					if (k_q == scke_pkg::LAST_BIN) begin
						state_q <= S_FINISH;
					end else begin
						k_q <= k_q + 1'b1;
						l_q <= '0;
						state_q <= S_LOAD;
					end
				end
				S_FINISH: begin
					// hold until the result register is free
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/shift_cipher_key_estimator.sv =====
// Shift-cipher key estimator. Bytes of a message arrive one per transaction
// and are taken one per clock cycle while no scoring pass is running; letters
// A-Z and a-z are counted into a 26-bin histogram, everything else is dropped,
// and letters past MAX_LEN are dropped with the overflow flag set. The
// transaction marked last is counted too and then starts the scoring pass: for
// each shift 0..25 the 24 letters with a nonzero expected frequency each go
// through count lookup, difference, square and an iterative divider that resolves
// 4 quotient bits per cycle in STEPS = ceil(2*ceil(log2(1000*MAX_LEN+1))/4) steps
// (13 at the default MAX_LEN). The input stays closed for the whole scoring
// pass, plus any wait for the previous result to be taken. The result carries
// the lowest-shift minimum score, letter total and overflow; the histogram is
// cleared when it is posted, and input reopens while the result waits in its
// output register.
module shift_cipher_key_estimator #(
	parameter int MAX_LEN = scke_pkg::MAX_LEN_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  scke_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output scke_pkg::result_t result
);

	scke_pkg::cmd_t cmd;
	scke_pkg::sts_t sts;

	scke_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_last  (item.last),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	scke_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== verif/shift_cipher_key_estimator_checker.sv =====
module shift_cipher_key_estimator_checker #(
	parameter int MAX_LEN = 65535
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  scke_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  scke_pkg::result_t result,
	output int                mismatches,
	output int                pending,
	output int                checked
);

	localparam int LETTERS = 26;
	localparam logic [63:0] SCORE_CEIL = (64'd1 << 57) - 64'd1;
	localparam logic [63:0] OBSERVED_SCALE = 64'd1000;
	localparam int unsigned TOTAL_CEIL = 65535;
	localparam int REPORT_LIMIT = 10;

	localparam logic [7:0] CAP_A = 8'h41;
	localparam logic [7:0] CAP_Z = 8'h5A;
	localparam logic [7:0] LOW_A = 8'h61;
	localparam logic [7:0] LOW_Z = 8'h7A;

	// English letter frequency A..Z in tenths of a percent
	localparam int unsigned FREQ_TENTHS [LETTERS] = '{
		139, 10, 44, 54, 122, 10, 12, 8, 69, 4,
		1, 28, 42, 53, 108, 29, 9, 69, 79, 49,
		40, 13, 0, 3, 0, 4
	};

	int unsigned       hist [LETTERS];
	int unsigned       letters;
	bit                dropped;
	scke_pkg::result_t estimates [$];
	scke_pkg::result_t want;

	function automatic void clear_histogram();
		foreach (hist[i])
			hist[i] = 0;
		letters = 0;
		dropped = 1'b0;
	endfunction

	function automatic void tally(logic [7:0] c);
		int bin;
		if (c >= CAP_A && c <= CAP_Z)
			bin = int'(c - CAP_A);
		else if (c >= LOW_A && c <= LOW_Z)
			bin = int'(c - LOW_A);
		else
			return;
		// drop letters once the message is full
		if (letters >= MAX_LEN) begin
			dropped = 1'b1;
			return;
		end
		hist[bin]++;
		letters++;
	endfunction

	function automatic logic [63:0] shift_score(int k);
		logic [63:0] sum;
		logic [63:0] obs;
		logic [63:0] expv;
		logic [63:0] diff;
		sum = 64'd0;
		for (int l = 0; l < LETTERS; l++) begin
			if (FREQ_TENTHS[l] != 0) begin
				obs = OBSERVED_SCALE * 64'(hist[(l + k) % LETTERS]);
				expv = 64'(FREQ_TENTHS[l]) * 64'(letters);
				diff = (obs >= expv) ? obs - expv : expv - obs;
				sum = sum + (diff * diff) / 64'(FREQ_TENTHS[l]);
				if (sum > SCORE_CEIL)
					sum = SCORE_CEIL;
			end
		end
		return sum;
	endfunction

	function automatic scke_pkg::result_t estimate_key();
		scke_pkg::result_t r;
		logic [63:0]       s;
		logic [63:0]       best;
		int                best_k;
		best = 64'd0;
		best_k = 0;
		// strict compare keeps the lowest shift on ties
		for (int k = 0; k < LETTERS; k++) begin
			s = shift_score(k);
			if (k == 0 || s < best) begin
				best = s;
				best_k = k;
			end
		end
		r.best_key = 5'(best_k);
		r.best_score = best[56:0];
		r.letter_total = (letters > TOTAL_CEIL) ? 16'hFFFF : 16'(letters);
		r.overflow = dropped;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_histogram();
			estimates.delete();
			mismatches = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (estimates.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected result: key %0d score %0d total %0d overflow %0b",
							result.best_key, result.best_score, result.letter_total,
							result.overflow);
				end else begin
					want = estimates.pop_front();
					checked++;
					if (want.best_key !== result.best_key ||
							want.best_score !== result.best_score ||
							want.letter_total !== result.letter_total ||
							want.overflow !== result.overflow) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("result %0d: got key %0d score %0d total %0d overflow %0b",
								checked, result.best_key, result.best_score,
								result.letter_total, result.overflow);
							$display("result %0d: expected key %0d score %0d total %0d overflow %0b",
								checked, want.best_key, want.best_score,
								want.letter_total, want.overflow);
						end
					end
				end
			end
			if (item_valid && item_ready) begin
				tally(item.char_code);
				if (item.last) begin
					estimates.push_back(estimate_key());
					clear_histogram();
				end
			end
			pending = estimates.size();
		end
	end

endmodule

// ===== verif/shift_cipher_key_estimator_test.sv =====
module shift_cipher_key_estimator_test;

	localparam int MAX_LEN = 65535;
	localparam int LIMIT = 120000000;
	localparam int HOLD_CYCLES = 40000;
	localparam int PHASE_ITEMS = 475;
	localparam int PHASE_MESSAGES = 10;
	localparam int DRAIN_CYCLES = 500;

	localparam logic [7:0] NUL = 8'h00;
	localparam logic [7:0] SPACE = 8'h20;
	localparam logic [7:0] PERIOD = 8'h2E;
	localparam logic [7:0] DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOW_E = 8'h65;

	// bytes on both sides of each letter range, plus 0x80 and the top of the byte range
	localparam logic [7:0] EDGE_BYTES [10] = '{
		8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B, 8'h80, 8'hFF
	};

	typedef enum int {
		MSG_TEXT,
		MSG_NOISE,
		MSG_REPEAT,
		MSG_UNIFORM
	} message_kind_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	scke_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	scke_pkg::result_t result;

	int mismatches;
	int pending;
	int checked;

	bit holding = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int messages_sent = 0;
	int bytes_sent = 0;
	int cycles = 0;

	string common_letters = "etaoinshrdlcumwfgypbvkjxqz";

	always #2 clk = ~clk;

	shift_cipher_key_estimator #(
		.MAX_LEN(MAX_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	shift_cipher_key_estimator_checker #(
		.MAX_LEN(MAX_LEN)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
		$display("== FAIL ==");
		$finish;
	end

	initial forever begin
		@(negedge clk);
		result_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic hold_results(int n);
		@(posedge clk);
		holding = 1'b1;
		repeat (n) @(posedge clk);
		holding = 1'b0;
	endtask

	// call at a falling edge; returns at the falling edge after the transaction
	task automatic send_item(logic [7:0] c, logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{char_code: c, last: l};
		do
			@(posedge clk);
		while (!(item_valid && item_ready));
		bytes_sent++;
		messages_sent += int'(l);
		@(negedge clk);
	endtask

	function automatic logic [7:0] letter_byte(int bin);
		return ($urandom_range(1) ? scke_pkg::UPPER_A : scke_pkg::LOWER_A) + 8'(bin);
	endfunction

	function automatic logic [7:0] filler_byte();
		unique case ($urandom_range(3))
			0: return SPACE;
			1: return PERIOD;
			2: return DIGIT_0 + 8'($urandom_range(9));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_message(message_kind_t kind, int len);
		int         key;
		int         base;
		int         bin;
		logic [7:0] c;
		key = $urandom_range(25);
		base = $urandom_range(25);
		for (int i = 0; i < len; i++) begin
			unique case (kind)
				MSG_TEXT: begin
					if ($urandom_range(5) == 0) begin
						c = filler_byte();
					end else begin
						// skew toward frequent letters, then apply the shift
						bin = int'(common_letters[($urandom_range(25) * $urandom_range(25)) / 25])
							- int'(scke_pkg::LOWER_A);
						c = letter_byte((bin + key) % 26);
					end
				end
				MSG_NOISE: c = 8'($urandom_range(255));
				MSG_REPEAT: c = letter_byte(base);
				default: c = letter_byte((base + i) % 26);
			endcase
			send_item(c, i == len - 1);
		end
	endtask

	task automatic random_message();
		int            pick;
		int            len;
		message_kind_t kind;
		pick = $urandom_range(99);
		if (pick < 65)
			kind = MSG_TEXT;
		else if (pick < 80)
			kind = MSG_NOISE;
		else if (pick < 90)
			kind = MSG_REPEAT;
		else
			kind = MSG_UNIFORM;
		if (kind == MSG_UNIFORM)
			len = 26 * $urandom_range(1, 3);
		else if ($urandom_range(9) == 0)
			len = $urandom_range(61, 250);
		else
			len = $urandom_range(1, 60);
		send_message(kind, len);
	endtask

	initial begin
		int start_items;
		int start_messages;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message, range edges, a single letter, a non-letter last byte
		send_item(NUL, 1'b1);
		foreach (EDGE_BYTES[i])
			send_item(EDGE_BYTES[i], 1'b0);
		send_item(CHAR_LOW_E, 1'b1);
		send_item(CHAR_Z, 1'b1);
		repeat (6) send_item(letter_byte($urandom_range(25)), 1'b0);
		send_item(SPACE, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			unique case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 70;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 70;
				end
				default: begin
					send_idle_pct = 17;
					recv_stall_pct = 17;
				end
			endcase
			start_items = bytes_sent;
			start_messages = messages_sent;
			while (bytes_sent - start_items < PHASE_ITEMS ||
					messages_sent - start_messages < PHASE_MESSAGES)
				random_message();
			if (phase == 0) begin
				// hold results back long enough to back up the input
				fork
					hold_results(HOLD_CYCLES);
				join_none
				repeat (3) send_message(MSG_TEXT, $urandom_range(5, 20));
			end
		end
		item_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d messages in %0d bytes, %0d results checked, letter range edges included",
			messages_sent, bytes_sent, checked);
		$display("idling mixes: none, sender 70%%, receiver 70%%, both 17%%; %0d-cycle hold-off",
			HOLD_CYCLES);
		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
